>>> rtl/lrdc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrdc_pkg: shared types and constants of the lamp remote dimming controller
// Key codes, register map, item/result structs and fixed lamp constants.
// ----------------------------------------------------------------------------
package lrdc_pkg;

  localparam int unsigned ADDR_W    = 3;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned KEY_W     = 4;
  localparam int unsigned LEVEL_W   = 6;
  localparam int unsigned DUTY_W    = 9;
  localparam int unsigned BEEP_W    = 2;
  localparam int unsigned TIMER_W   = 12;
  localparam int unsigned TICK_W    = 7;
  localparam int unsigned DEB_W     = 4;
  localparam int unsigned STEP_W    = 8;

  localparam logic [CHAN_W-1:0]  CODE_ONE_RST = 8'd1;
  localparam logic [CHAN_W-1:0]  CODE_TWO_RST = 8'd2;
  localparam logic [LEVEL_W-1:0] LEVEL_FULL   = 6'd56;
  localparam logic [LEVEL_W-1:0] LEVEL_MID    = 6'd43;
  localparam logic [LEVEL_W-1:0] LEVEL_LOW    = 6'd35;
  localparam logic [TIMER_W-1:0] TIMER_30MIN  = 12'd1800;
  localparam logic [TIMER_W-1:0] TIMER_60MIN  = 12'd3600;
  localparam logic [DEB_W-1:0]   DEB_SAT      = 4'd15;
  localparam logic [BEEP_W-1:0]  BEEP_NONE    = 2'd0;
  localparam logic [BEEP_W-1:0]  BEEP_ONE     = 2'd1;
  localparam logic [BEEP_W-1:0]  BEEP_TWO     = 2'd2;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_FRAME = 1'b1
  } cmd_e;

  typedef enum logic [KEY_W-1:0] {
    KEY_TIMER30 = 4'd0,
    KEY_TIMER60 = 4'd1,
    KEY_FULL    = 4'd2,
    KEY_MID     = 4'd3,
    KEY_LOW     = 4'd4,
    KEY_COLOUR  = 4'd5,
    KEY_NIGHT   = 4'd6,
    KEY_POWER   = 4'd7
  } key_e;

  // Register index as decoded from paddr[2]
  typedef enum logic {
    REG_CODE_ONE = 1'b0,
    REG_CODE_TWO = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [CHAN_W-1:0] code_one;
    logic [CHAN_W-1:0] code_two;
  } cfg_t;

  typedef struct packed {
    logic              cmd;
    logic [KEY_W-1:0]  key;
    logic [CHAN_W-1:0] frame_channel;
    logic              switch_pos;
  } item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               night_lamp;
    logic               colour;
    logic [BEEP_W-1:0]  beeps;
  } result_t;

endpackage
`default_nettype wire

>>> rtl/lrdc_apb_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrdc_apb_regs: configuration registers
// Two channel code registers behind an APB-style slave, zero wait states.
// ----------------------------------------------------------------------------
module lrdc_apb_regs
  import lrdc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);

  cfg_t     cfg_q, cfg_d;
  logic     wr_en;
  reg_idx_e idx;

  // word index only; byte offset bits ignored
  assign idx    = reg_idx_e'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_CODE_ONE: cfg_d.code_one = pwdata[CHAN_W-1:0];
        REG_CODE_TWO: cfg_d.code_two = pwdata[CHAN_W-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CODE_ONE: prdata = {{(DATA_W-CHAN_W){1'b0}}, cfg_q.code_one};
      REG_CODE_TWO: prdata = {{(DATA_W-CHAN_W){1'b0}}, cfg_q.code_two};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.code_one <= CODE_ONE_RST;
      cfg_q.code_two <= CODE_TWO_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/lrdc_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrdc_core: lamp state and combinational item update
// Holds all lamp state; applies one tick or frame per cycle when fire_i is set.
// ----------------------------------------------------------------------------
module lrdc_core
  import lrdc_pkg::*;
#(
  parameter int unsigned FADE_STEPS       = 50,
  parameter int unsigned TICKS_PER_SECOND = 100,
  parameter int unsigned DEBOUNCE_TICKS   = 10
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic fire_i,
  input  item_t     item_i,
  input  cfg_t      cfg_i,
  output result_t   res_o
);

  // Fade product level*step, tracked incrementally; divided by FADE_STEPS
  // through a reciprocal multiply that is exact over the product range.
  localparam int unsigned PROD_W  = $clog2(63 * FADE_STEPS + 1);
  localparam int unsigned SHIFT   = PROD_W + 8;
  localparam int unsigned RECIP_W = SHIFT + 1;
  localparam int unsigned QUOT_W  = PROD_W + RECIP_W;
  localparam longint unsigned RECIP_VAL =
      ((64'd1 << SHIFT) + 64'(FADE_STEPS) - 64'd1) / 64'(FADE_STEPS);

  localparam logic [RECIP_W-1:0] RECIP      = RECIP_W'(RECIP_VAL);
  localparam logic [PROD_W-1:0]  STEPS_PROD = PROD_W'(FADE_STEPS);
  localparam logic [STEP_W-1:0]  STEPS_MAX  = STEP_W'(FADE_STEPS);
  localparam logic [TICK_W-1:0]  TPS        = TICK_W'(TICKS_PER_SECOND);
  localparam logic [DEB_W-1:0]   DEB_LIMIT  = DEB_W'(DEBOUNCE_TICKS);

  logic [LEVEL_W-1:0] level_q, level_d, saved_level_q, saved_level_d;
  logic [LEVEL_W-1:0] fade_base_q, fade_base_d;
  logic               night_q, night_d, lamp_night_q, lamp_night_d;
  logic               colour_q, colour_d, saved_colour_q, saved_colour_d;
  logic [TIMER_W-1:0] limit_q, limit_d, elapsed_q, elapsed_d, elapsed_inc;
  logic [TICK_W-1:0]  tick_q, tick_d, tick_inc;
  logic               fade_act_q, fade_act_d, rising_q, rising_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [PROD_W-1:0]  prod_q, prod_d, prod_next;
  logic [QUOT_W-1:0]  quot_full;
  logic [LEVEL_W-1:0] fade_lvl;
  logic [DEB_W-1:0]   deb_hi_q, deb_hi_d, deb_lo_q, deb_lo_d;
  logic [CHAN_W-1:0]  chan_q, chan_d;
  logic [BEEP_W-1:0]  beeps;
  logic               taken;

  assign prod_next = rising_q ? (prod_q + PROD_W'(fade_base_q))
                              : (prod_q - PROD_W'(fade_base_q));
  assign quot_full = QUOT_W'(prod_next) * QUOT_W'(RECIP);
  assign fade_lvl  = quot_full[SHIFT +: LEVEL_W];
  assign tick_inc    = tick_q + TICK_W'(1);
  assign elapsed_inc = elapsed_q + TIMER_W'(1);

  always_comb begin
    level_d        = level_q;
    saved_level_d  = saved_level_q;
    fade_base_d    = fade_base_q;
    night_d        = night_q;
    lamp_night_d   = lamp_night_q;
    colour_d       = colour_q;
    saved_colour_d = saved_colour_q;
    limit_d        = limit_q;
    elapsed_d      = elapsed_q;
    tick_d         = tick_q;
    fade_act_d     = fade_act_q;
    rising_d       = rising_q;
    step_d         = step_q;
    prod_d         = prod_q;
    deb_hi_d       = deb_hi_q;
    deb_lo_d       = deb_lo_q;
    chan_d         = chan_q;
    beeps          = BEEP_NONE;
    taken          = 1'b0;

    if (item_i.cmd == CMD_TICK) begin
      // switch debounce, saturating counters
      if (item_i.switch_pos) begin
        deb_lo_d = '0;
        chan_d   = (deb_hi_q > DEB_LIMIT) ? cfg_i.code_one : '0;
        if (deb_hi_q != DEB_SAT) deb_hi_d = deb_hi_q + DEB_W'(1);
      end else begin
        deb_hi_d = '0;
        chan_d   = (deb_lo_q > DEB_LIMIT) ? cfg_i.code_two : '0;
        if (deb_lo_q != DEB_SAT) deb_lo_d = deb_lo_q + DEB_W'(1);
      end

      // seconds and off-timer
      if (tick_inc >= TPS) begin
        tick_d = '0;
        if (limit_q != '0) begin
          elapsed_d = elapsed_inc;
          if (elapsed_inc >= limit_q) begin
            limit_d      = '0;
            elapsed_d    = '0;
            level_d      = '0;
            lamp_night_d = 1'b0;
          end
        end
      end else begin
        tick_d = tick_inc;
      end

      // colour fade: down to zero, swap colour, back up
      if (fade_act_q) begin
        prod_d  = prod_next;
        level_d = fade_lvl;
        if (!rising_q) begin
          step_d = step_q - STEP_W'(1);
          if (step_q == STEP_W'(1)) begin
            rising_d = 1'b1;
            colour_d = ~colour_q;
          end
        end else begin
          step_d = step_q + STEP_W'(1);
          if (step_q + STEP_W'(1) == STEPS_MAX) begin
            fade_act_d     = 1'b0;
            rising_d       = 1'b0;
            saved_level_d  = fade_lvl;
            saved_colour_d = colour_q;
          end
        end
      end
    end else if (item_i.frame_channel == chan_q && !fade_act_q) begin
      taken = 1'b1;
      beeps = BEEP_ONE;
      unique case (item_i.key)
        KEY_TIMER30, KEY_TIMER60: begin
          if (limit_q == '0) begin
            limit_d = (item_i.key == KEY_TIMER30) ? TIMER_30MIN : TIMER_60MIN;
          end else begin
            limit_d   = '0;
            elapsed_d = '0;
            beeps     = BEEP_TWO;
          end
        end
        KEY_FULL, KEY_MID, KEY_LOW: begin
          priority case (item_i.key)
            KEY_FULL: level_d = LEVEL_FULL;
            KEY_MID:  level_d = LEVEL_MID;
            default:  level_d = LEVEL_LOW;
          endcase
          night_d        = 1'b0;
          saved_level_d  = level_d;
          saved_colour_d = colour_q;
        end
        KEY_COLOUR: begin
          fade_base_d = level_q;
          fade_act_d  = 1'b1;
          prod_d      = PROD_W'(level_q) * STEPS_PROD;
        end
        KEY_NIGHT: begin
          level_d = '0;
          night_d = ~night_q;
        end
        KEY_POWER: begin
          if (level_q == '0) begin
            limit_d  = '0;
            level_d  = saved_level_q;
            colour_d = saved_colour_q;
          end else begin
            level_d = '0;
          end
          night_d = 1'b0;
        end
        default: begin
          taken = 1'b0;
          beeps = BEEP_NONE;
        end
      endcase
      if (taken) lamp_night_d = night_d;
    end
  end

  assign res_o.level      = level_d;
  assign res_o.night_lamp = lamp_night_d;
  assign res_o.colour     = colour_d;
  assign res_o.beeps      = beeps;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q        <= LEVEL_FULL;
      saved_level_q  <= LEVEL_FULL;
      fade_base_q    <= '0;
      night_q        <= 1'b0;
      lamp_night_q   <= 1'b0;
      colour_q       <= 1'b0;
      saved_colour_q <= 1'b0;
      limit_q        <= '0;
      elapsed_q      <= '0;
      tick_q         <= '0;
      fade_act_q     <= 1'b0;
      rising_q       <= 1'b0;
      step_q         <= STEPS_MAX;
      prod_q         <= '0;
      deb_hi_q       <= '0;
      deb_lo_q       <= '0;
      chan_q         <= '0;
    end else if (fire_i) begin
      level_q        <= level_d;
      saved_level_q  <= saved_level_d;
      fade_base_q    <= fade_base_d;
      night_q        <= night_d;
      lamp_night_q   <= lamp_night_d;
      colour_q       <= colour_d;
      saved_colour_q <= saved_colour_d;
      limit_q        <= limit_d;
      elapsed_q      <= elapsed_d;
      tick_q         <= tick_d;
      fade_act_q     <= fade_act_d;
      rising_q       <= rising_d;
      step_q         <= step_d;
      prod_q         <= prod_d;
      deb_hi_q       <= deb_hi_d;
      deb_lo_q       <= deb_lo_d;
      chan_q         <= chan_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/lamp_remote_dimming_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lamp_remote_dimming_controller: remote-keyed lamp dimmer with colour fade
// Top level: input register, state update core, result register, APB regs.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i/in_ready_o): one transaction per 10 ms tick
//    (cmd_i = 0, switch_pos_i sampled) or per decoded remote frame
//    (cmd_i = 1, key_i and frame_channel_i used).
//  - Output channel (out_valid_o/out_ready_i): exactly one result transaction
//    per input transaction, in order: PWM duty (level x 5), night lamp,
//    cool/warm shut bits and the beep request of that transaction.
//  - The accepted transaction waits in the input register until applied; its
//    result then goes to the result register, which drives out_valid_o.
//    Throughput: one transaction per cycle while the receiver does not stall;
//    the state update is combinational logic between the input register and
//    the result register, the fade divide being one reciprocal multiply.
//  - When the receiver stalls, the result register holds and the input
//    register still takes one more transaction; in_ready_o drops only when
//    both are full.
//  - Reset (rst_ni, asynchronous, active low) empties both registers and
//    loads the lamp state: level 56, night off, colour 0, timer stopped,
//    channel codes 1 and 2, active channel 0 until the switch settles.
//  - The user writes the channel codes over APB (byte addresses 0 and 4)
//    only while the block is idle (not enforced); pready is tied high.
// ----------------------------------------------------------------------------
module lamp_remote_dimming_controller
  import lrdc_pkg::*;
#(
  parameter int unsigned FADE_STEPS       = 50,
  parameter int unsigned TICKS_PER_SECOND = 100,
  parameter int unsigned DEBOUNCE_TICKS   = 10
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  // input channel
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              cmd_i,
  input  wire logic [KEY_W-1:0]  key_i,
  input  wire logic [CHAN_W-1:0] frame_channel_i,
  input  wire logic              switch_pos_i,
  // output channel
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic      [DUTY_W-1:0] pwm_duty_o,
  output logic                   night_lamp_o,
  output logic                   cool_shut_o,
  output logic                   warm_shut_o,
  output logic      [BEEP_W-1:0] beep_count_o
);

  cfg_t    cfg;
  item_t   item_q;
  logic    in_valid_q;
  result_t res, res_q;
  logic    out_valid_q;
  logic    fire;

  lrdc_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The held transaction is applied when the result slot is free or being
  // emptied this cycle; the input register then refills in the same cycle.
  assign fire       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.cmd           <= cmd_i;
      item_q.key           <= key_i;
      item_q.frame_channel <= frame_channel_i;
      item_q.switch_pos    <= switch_pos_i;
    end
  end

  lrdc_core #(
    .FADE_STEPS       (FADE_STEPS),
    .TICKS_PER_SECOND (TICKS_PER_SECOND),
    .DEBOUNCE_TICKS   (DEBOUNCE_TICKS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res;
    end
  end

  // duty = level x 5 as shift and add
  assign pwm_duty_o   = {1'b0, res_q.level, 2'b00} + DUTY_W'(res_q.level);
  assign out_valid_o  = out_valid_q;
  assign night_lamp_o = res_q.night_lamp;
  assign cool_shut_o  = res_q.colour;
  assign warm_shut_o  = ~res_q.colour;
  assign beep_count_o = res_q.beeps;

endmodule
`default_nettype wire

>>> rtl/lrdc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrdc_checker: port-level checks for the lamp controller
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
module lrdc_checker
  import lrdc_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire logic              cmd_i,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire logic [DUTY_W-1:0] pwm_duty_o,
  input wire logic              cool_shut_o,
  input wire logic              warm_shut_o,
  input wire logic [BEEP_W-1:0] beep_count_o
);

  localparam logic [DUTY_W-1:0] DUTY_MAX = DUTY_W'(LEVEL_FULL) * DUTY_W'(5);

  // stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pwm_duty_o)
      && $stable(beep_count_o) && $stable(cool_shut_o))
    else $error("result changed while stalled");

  // cool and warm shut bits are always complementary on a result
  a_shut_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cool_shut_o != warm_shut_o)
    else $error("cool and warm shut both equal");

  // duty never exceeds full level
  a_duty_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pwm_duty_o <= DUTY_MAX)
    else $error("duty above full brightness");

  // ticks never beep; only checked when the block was otherwise empty
  a_tick_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (cmd_i == CMD_TICK) && !out_valid_o
      && !$past(in_valid_i && in_ready_o)
      |-> ##2 out_valid_o && beep_count_o == BEEP_NONE)
    else $error("tick produced a beep");

endmodule

bind lamp_remote_dimming_controller lrdc_checker u_lrdc_checker (.*);
`default_nettype wire

>>> sim/lrdc_lamp_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrdc_lamp_check: lamp state tracker and result comparator
// Follows the APB port and both channels of the dimmer, keeps its own copy
// of the lamp state, works out the result of every accepted transaction and
// compares it with the result the block hands out, oldest first.
// ----------------------------------------------------------------------------
module lrdc_lamp_check
  import lrdc_pkg::*;
#(
  parameter int unsigned FADE_STEPS       = 50,
  parameter int unsigned TICKS_PER_SECOND = 100,
  parameter int unsigned DEBOUNCE_TICKS   = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic [DATA_W-1:0] prdata,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic              cmd_i,
  input  logic [KEY_W-1:0]  key_i,
  input  logic [CHAN_W-1:0] frame_channel_i,
  input  logic              switch_pos_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [DUTY_W-1:0] pwm_duty_i,
  input  logic              night_lamp_i,
  input  logic              cool_shut_i,
  input  logic              warm_shut_i,
  input  logic [BEEP_W-1:0] beep_count_i,
  output int                pending_o,
  output int                fails_o
);

  localparam int unsigned DUTY_PER_LEVEL = 5;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              night;
    logic              cool;
    logic              warm;
    logic [BEEP_W-1:0] beeps;
  } lamp_out_t;

  logic [CHAN_W-1:0]  code_one_q, code_two_q;
  logic [LEVEL_W-1:0] level_q, saved_level_q, fade_base_q;
  logic               night_q, lamp_night_q, colour_q, saved_colour_q;
  logic [TIMER_W-1:0] limit_q, elapsed_q;
  logic [TICK_W-1:0]  tick_q;
  logic               fade_on_q, fade_up_q;
  logic [STEP_W-1:0]  step_q;
  logic [DEB_W-1:0]   deb_hi_q, deb_lo_q;
  logic [CHAN_W-1:0]  active_q;

  lamp_out_t lamp_expect_q[$];
  lamp_out_t seen, want;
  int        pending_cnt = 0;
  int        fail_cnt    = 0;

  assign pending_o = pending_cnt;
  assign fails_o   = fail_cnt;

  function automatic logic [LEVEL_W-1:0] fade_target(input logic [LEVEL_W-1:0] base,
                                                     input logic [STEP_W-1:0]  step);
    int unsigned prod;
    prod = base * step;
    prod = prod / FADE_STEPS;
    return prod[LEVEL_W-1:0];
  endfunction

  task automatic report_fail(input string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("[%0t] lamp check: %s", $time, msg);
  endtask

  // one accepted transaction: tick or remote frame
  task automatic step_lamp(input logic cmd, input logic [KEY_W-1:0] key,
                           input logic [CHAN_W-1:0] chan, input logic sw,
                           output lamp_out_t res);
    logic [BEEP_W-1:0] beeps;
    beeps = BEEP_NONE;
    if (cmd == CMD_TICK) begin
      // debounce: test the old count, then count up with saturation
      if (sw) begin
        deb_lo_q = '0;
        active_q = (deb_hi_q > DEBOUNCE_TICKS) ? code_one_q : '0;
        if (deb_hi_q < DEB_SAT) deb_hi_q = deb_hi_q + 1'b1;
      end else begin
        deb_hi_q = '0;
        active_q = (deb_lo_q > DEBOUNCE_TICKS) ? code_two_q : '0;
        if (deb_lo_q < DEB_SAT) deb_lo_q = deb_lo_q + 1'b1;
      end
      tick_q = tick_q + 1'b1;
      if (tick_q >= TICKS_PER_SECOND) begin
        tick_q = '0;
        if (limit_q != '0) begin
          elapsed_q = elapsed_q + 1'b1;
          if (elapsed_q >= limit_q) begin
            limit_q      = '0;
            elapsed_q    = '0;
            level_q      = '0;
            lamp_night_q = 1'b0;
          end
        end
      end
      if (fade_on_q) begin
        if (!fade_up_q) begin
          step_q  = step_q - 1'b1;
          level_q = fade_target(fade_base_q, step_q);
          if (step_q == '0) begin
            fade_up_q = 1'b1;
            colour_q  = ~colour_q;
          end
        end else begin
          step_q  = step_q + 1'b1;
          level_q = fade_target(fade_base_q, step_q);
          if (step_q == FADE_STEPS) begin
            fade_on_q      = 1'b0;
            fade_up_q      = 1'b0;
            saved_level_q  = level_q;
            saved_colour_q = colour_q;
          end
        end
      end
    end else if (chan == active_q && !fade_on_q) begin
      beeps = BEEP_ONE;
      case (key)
        KEY_TIMER30, KEY_TIMER60: begin
          if (limit_q == '0) begin
            limit_q = (key == KEY_TIMER30) ? TIMER_30MIN : TIMER_60MIN;
          end else begin
            limit_q   = '0;
            elapsed_q = '0;
            beeps     = BEEP_TWO;
          end
        end
        KEY_FULL, KEY_MID, KEY_LOW: begin
          level_q = (key == KEY_FULL) ? LEVEL_FULL : (key == KEY_MID) ? LEVEL_MID : LEVEL_LOW;
          night_q        = 1'b0;
          saved_level_q  = level_q;
          saved_colour_q = colour_q;
        end
        KEY_COLOUR: begin
          fade_base_q = level_q;
          fade_on_q   = 1'b1;
        end
        KEY_NIGHT: begin
          level_q = '0;
          night_q = ~night_q;
        end
        KEY_POWER: begin
          // power on clears the timer limit but leaves the elapsed count
          if (level_q == '0) begin
            limit_q  = '0;
            level_q  = saved_level_q;
            colour_q = saved_colour_q;
          end else begin
            level_q = '0;
          end
          night_q = 1'b0;
        end
        default: beeps = BEEP_NONE;
      endcase
      if (beeps != BEEP_NONE) lamp_night_q = night_q;
    end
    res.duty  = DUTY_W'(level_q * DUTY_PER_LEVEL);
    res.night = lamp_night_q;
    res.cool  = colour_q;
    res.warm  = ~colour_q;
    res.beeps = beeps;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_one_q     = CODE_ONE_RST;
      code_two_q     = CODE_TWO_RST;
      level_q        = LEVEL_FULL;
      saved_level_q  = LEVEL_FULL;
      night_q        = 1'b0;
      lamp_night_q   = 1'b0;
      colour_q       = 1'b0;
      saved_colour_q = 1'b0;
      limit_q        = '0;
      elapsed_q      = '0;
      tick_q         = '0;
      fade_on_q      = 1'b0;
      fade_up_q      = 1'b0;
      step_q         = STEP_W'(FADE_STEPS);
      fade_base_q    = '0;
      deb_hi_q       = '0;
      deb_lo_q       = '0;
      active_q       = '0;
      lamp_expect_q.delete();
      pending_cnt    = 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (reg_idx_e'(paddr[2]))
            REG_CODE_ONE: code_one_q = pwdata[CHAN_W-1:0];
            default:      code_two_q = pwdata[CHAN_W-1:0];
          endcase
        end else if (prdata !== DATA_W'(reg_idx_e'(paddr[2]) == REG_CODE_ONE ?
                                        code_one_q : code_two_q)) begin
          report_fail($sformatf("register read at %0d: exp %0d got %0d", paddr,
                                reg_idx_e'(paddr[2]) == REG_CODE_ONE ? code_one_q : code_two_q,
                                prdata));
        end
      end
      if (out_valid_i && out_ready_i) begin
        seen.duty  = pwm_duty_i;
        seen.night = night_lamp_i;
        seen.cool  = cool_shut_i;
        seen.warm  = warm_shut_i;
        seen.beeps = beep_count_i;
        if (lamp_expect_q.size() == 0) begin
          report_fail("result transaction with nothing expected");
        end else begin
          want = lamp_expect_q.pop_front();
          pending_cnt--;
          if (seen !== want)
            report_fail($sformatf({"exp duty %0d night %0b cool %0b warm %0b beeps %0d, ",
                                   "got duty %0d night %0b cool %0b warm %0b beeps %0d"},
                                  want.duty, want.night, want.cool, want.warm, want.beeps,
                                  seen.duty, seen.night, seen.cool, seen.warm, seen.beeps));
        end
      end
      if (in_valid_i && in_ready_i) begin
        step_lamp(cmd_i, key_i, frame_channel_i, switch_pos_i, want);
        lamp_expect_q.push_back(want);
        pending_cnt++;
      end
    end
  end

endmodule

>>> sim/tb_lamp_remote_dimming_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lamp_remote_dimming_controller: stimulus and verdict for the lamp dimmer
// Drives ticks and remote frames through the input channel, stalls the result
// channel at random, reprograms the channel codes between phases and works
// the timer keys. The tracker module does all prediction.
// ----------------------------------------------------------------------------
module tb_lamp_remote_dimming_controller;
  import lrdc_pkg::*;

  localparam int unsigned FADE_STEPS       = 50;
  localparam int unsigned TICKS_PER_SECOND = 100;
  localparam int unsigned DEBOUNCE_TICKS   = 10;

  // generous for about 500 transactions, even with every stall
  localparam int unsigned CYCLE_LIMIT   = 200_000;
  // first and last of the key codes the block ignores
  localparam logic [KEY_W-1:0] KEY_SPARE_FIRST = 4'd8;
  localparam logic [KEY_W-1:0] KEY_SPARE_LAST  = 4'hF;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;
  logic              in_valid_i, in_ready_o, cmd_i, switch_pos_i;
  logic [KEY_W-1:0]  key_i;
  logic [CHAN_W-1:0] frame_channel_i;
  logic              out_valid_o, out_ready_i;
  logic [DUTY_W-1:0] pwm_duty_o;
  logic              night_lamp_o, cool_shut_o, warm_shut_o;
  logic [BEEP_W-1:0] beep_count_o;

  int                pending, fails;
  int unsigned       cycle_cnt = 0;
  // switch level last driven on a tick, and the codes last programmed
  logic              cur_sw;
  logic [CHAN_W-1:0] code_one_tb, code_two_tb;
  // idling on the input side (gap_en) and on the result side (stall_en)
  bit                gap_en, stall_en;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  lamp_remote_dimming_controller #(
    .FADE_STEPS      (FADE_STEPS),
    .TICKS_PER_SECOND(TICKS_PER_SECOND),
    .DEBOUNCE_TICKS  (DEBOUNCE_TICKS)
  ) dut (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .cmd_i, .key_i, .frame_channel_i, .switch_pos_i,
    .out_valid_o, .out_ready_i, .pwm_duty_o, .night_lamp_o, .cool_shut_o,
    .warm_shut_o, .beep_count_o
  );

  lrdc_lamp_check #(
    .FADE_STEPS      (FADE_STEPS),
    .TICKS_PER_SECOND(TICKS_PER_SECOND),
    .DEBOUNCE_TICKS  (DEBOUNCE_TICKS)
  ) u_lamp_check (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .prdata,
    .in_valid_i, .in_ready_i(in_ready_o), .cmd_i, .key_i, .frame_channel_i,
    .switch_pos_i,
    .out_valid_i(out_valid_o), .out_ready_i, .pwm_duty_i(pwm_duty_o),
    .night_lamp_i(night_lamp_o), .cool_shut_i(cool_shut_o),
    .warm_shut_i(warm_shut_o), .beep_count_i(beep_count_o),
    .pending_o(pending), .fails_o(fails)
  );

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result-side back-pressure: out_ready_i drops for random bursts while enabled.
  initial begin
    int unsigned n;
    out_ready_i = 1'b1;
    forever begin
      @(negedge clk_i);
      if (stall_en && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 12);
        out_ready_i <= 1'b0;
        repeat (n) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // Channel the block should be listening on once the switch has settled.
  function automatic logic [CHAN_W-1:0] chan_now();
    return cur_sw ? code_one_tb : code_two_tb;
  endfunction

  // Hold valid low for a stretch set by n; also ends any transaction left on the bus.
  task automatic pause_input(input int n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  // One input transaction: raised at a falling edge, held until accepted.
  task automatic send_item(input logic cmd, input logic [KEY_W-1:0] key,
                           input logic [CHAN_W-1:0] chan, input logic sw);
    @(negedge clk_i);
    in_valid_i      <= 1'b1;
    cmd_i           <= cmd;
    key_i           <= key;
    frame_channel_i <= chan;
    switch_pos_i    <= sw;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Ticks carry junk in the frame-only fields; the block must not look at it.
  task automatic send_ticks(input int unsigned n, input logic sw);
    cur_sw = sw;
    repeat (n) send_item(CMD_TICK, KEY_W'($urandom), CHAN_W'($urandom), sw);
  endtask

  task automatic press(input logic [KEY_W-1:0] key);
    send_item(CMD_FRAME, key, chan_now(), 1'($urandom));
  endtask

  // Mostly ticks and frames aimed at the listening channel; the rest are
  // spare keys, channel zero, the other side's code and random channels.
  task automatic send_random();
    int unsigned       r;
    logic [KEY_W-1:0]  key;
    logic [CHAN_W-1:0] chan;
    if (gap_en && $urandom_range(0, 6) == 0) pause_input($urandom_range(1, 12));
    if ($urandom_range(0, 99) < 55) begin
      if ($urandom_range(0, 29) == 0) cur_sw = ~cur_sw;
      send_item(CMD_TICK, KEY_W'($urandom), CHAN_W'($urandom), cur_sw);
    end else begin
      if ($urandom_range(0, 99) < 85) key = KEY_W'($urandom_range(KEY_TIMER30, KEY_POWER));
      else key = KEY_W'($urandom_range(KEY_SPARE_FIRST, KEY_SPARE_LAST));
      r = $urandom_range(0, 99);
      if (r < 60) chan = chan_now();
      else if (r < 72) chan = '0;
      else if (r < 80) chan = cur_sw ? code_two_tb : code_one_tb;
      else chan = CHAN_W'($urandom);
      send_item(CMD_FRAME, key, chan, 1'($urandom));
    end
  endtask

  // Stop sending and wait until every result is back.
  task automatic wait_for_results();
    pause_input(1);
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Two-phase APB transfer: setup, then access (pready is tied high).
  task automatic apb_access(input logic wr, input reg_idx_e idx,
                            input logic [CHAN_W-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= DATA_W'(val);
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic program_codes(input logic [CHAN_W-1:0] one, input logic [CHAN_W-1:0] two);
    wait_for_results();
    apb_access(1'b1, REG_CODE_ONE, one);
    apb_access(1'b1, REG_CODE_TWO, two);
    apb_access(1'b0, REG_CODE_ONE, '0);
    apb_access(1'b0, REG_CODE_TWO, '0);
    code_one_tb = one;
    code_two_tb = two;
  endtask

  initial begin
    int unsigned ph;
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_valid_i      = 1'b0;
    cmd_i           = CMD_TICK;
    key_i           = '0;
    frame_channel_i = '0;
    switch_pos_i    = 1'b0;
    cur_sw          = 1'b0;
    code_one_tb     = CODE_ONE_RST;
    code_two_tb     = CODE_TWO_RST;
    gap_en          = 1'b0;
    stall_en        = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset values of both channel code registers
    apb_access(1'b0, REG_CODE_ONE, '0);
    apb_access(1'b0, REG_CODE_TWO, '0);

    // While the switch is still debouncing the active channel is zero, so
    // frames on channel zero are taken; spare keys do nothing, no beep.
    send_item(CMD_FRAME, KEY_MID, '0, 1'b0);
    send_item(CMD_FRAME, KEY_SPARE_FIRST, '0, 1'b1);
    send_item(CMD_FRAME, KEY_SPARE_LAST, '0, 1'b1);
    send_item(CMD_FRAME, KEY_POWER, 8'hFF, 1'b0);
    // settle the switch high: channel code one becomes active
    send_ticks(12, 1'b1);
    // night toggles to level 0; power from off restores the saved level
    press(KEY_NIGHT);
    press(KEY_POWER);
    press(KEY_POWER);
    press(KEY_POWER);
    // second press of a running timer stops it with two beeps
    press(KEY_TIMER30);
    press(KEY_TIMER30);
    press(KEY_TIMER60);
    press(KEY_TIMER60);
    press(KEY_FULL);
    press(KEY_LOW);
    // keys are locked out while the colour fade runs
    press(KEY_COLOUR);
    press(KEY_FULL);
    send_ticks(3, 1'b1);

    // Random phases, one per code setting, extremes first.
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       program_codes(8'hFF, 8'h00);
        1:       program_codes(8'h00, 8'hFF);
        2:       program_codes(CHAN_W'($urandom), CHAN_W'($urandom));
        default: program_codes(8'h5A, 8'h5A);
      endcase
      repeat (5) begin
        gap_en   = $urandom_range(0, 3) != 0;
        stall_en = $urandom_range(0, 3) != 0;
        repeat (20) send_random();
      end
    end

    // closing stretch with no idling on either side
    gap_en   = 1'b0;
    stall_en = 1'b0;
    wait_for_results();
    repeat (12) @(negedge clk_i);
    repeat (60) send_random();

    wait_for_results();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    if (fails == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
